// ===== sv/dft_pkg.sv =====
// Shared types, constants and packet forming for the DShot frame transmitter.
// No dependencies; imported by every module of the block but dft_fifo.
package dft_pkg;

   localparam int TICK_BITS_DEFAULT   = 16;
   localparam int SLOT_BITS_DEFAULT   = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int THROTTLE_W    = 11;
   localparam int PACKET_W      = 16;
   localparam int CRC_W         = 4;
   localparam int CFG_TICK_W    = 16;
   localparam int CFG_SLOT_W    = 12;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int DATA_SLOTS    = 16;
   localparam int DATA_SLOT_W   = 4;

   localparam logic [CFG_TICK_W-1:0] BIT_PERIOD_RESET      = 16'd120;
   localparam logic [CFG_TICK_W-1:0] ONE_HIGH_TICKS_RESET  = 16'd89;
   localparam logic [CFG_TICK_W-1:0] ZERO_HIGH_TICKS_RESET = 16'd44;
   localparam logic [CFG_SLOT_W-1:0] FRAME_SLOTS_RESET     = 12'd17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PERIOD      = 2'd0,
      CSR_ONE_HIGH_TICKS  = 2'd1,
      CSR_ZERO_HIGH_TICKS = 2'd2,
      CSR_FRAME_SLOTS     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  run;
      logic                  load;
      logic [THROTTLE_W-1:0] throttle;
      logic                  telemetry_request;
   } req_type;

   typedef struct packed {
      logic line;
      logic frame_start;
      logic busy_res;
   } rsp_type;

   // classified tick as queued between front and back
   typedef struct packed {
      logic                run;
      logic                load;
      logic [PACKET_W-1:0] packet;
   } cmd_type;

   typedef struct packed {
      logic [CFG_TICK_W-1:0] bit_period;
      logic [CFG_TICK_W-1:0] one_high_ticks;
      logic [CFG_TICK_W-1:0] zero_high_ticks;
      logic [CFG_SLOT_W-1:0] frame_slots;
   } cfg_type;

   // word = throttle:tel, CRC is the XOR of its three nibbles, not inverted
   function automatic logic [PACKET_W-1:0] make_packet(
      input logic [THROTTLE_W-1:0] throttle,
      input logic                  tel
   );
      logic [THROTTLE_W:0] word;
      logic [CRC_W-1:0]    crc;
      word = {throttle, tel};
      crc  = word[3:0] ^ word[7:4] ^ word[11:8];
      return {word, crc};
   endfunction

endpackage

// ===== sv/dft_fifo.sv =====
// Small synchronous queue with full/empty flags, used on both sides of the engine.
// Depends on nothing but its parameters.
module dft_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/dft_front.sv =====
// Front end: takes tick beats, forms the packet with its CRC, queues them.
// Depends on dft_pkg and dft_fifo.
module dft_front
   import dft_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    cmd_take,
   output logic    cmd_valid,
   output cmd_type cmd
);

   cmd_type cmd_new;
   logic    cmd_empty;

   always_comb begin
      cmd_new.run    = req_data.run;
      cmd_new.load   = req_data.load;
      cmd_new.packet = make_packet(req_data.throttle, req_data.telemetry_request);
   end

   dft_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_new),
      .full    (req_full),
      .pop     (cmd_take),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/dft_back.sv =====
// Back end: frame/slot/tick timing engine, one queued tick per cycle while the result queue is not full.
// Depends on dft_pkg.
module dft_back
   import dft_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT,
   parameter int SLOT_BITS = SLOT_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   input  logic    out_full,
   output logic    cmd_take,
   output rsp_type rsp
);

   localparam int TICK_CW = (TICK_BITS > CFG_TICK_W) ? TICK_BITS + 1 : CFG_TICK_W + 1;
   localparam int SLOT_CW = (SLOT_BITS > CFG_SLOT_W) ? SLOT_BITS + 1 : CFG_SLOT_W + 1;

   logic [PACKET_W-1:0]  pending_packet_ff, pending_packet_in;
   logic                 packet_valid_ff, packet_valid_in;
   logic [PACKET_W-1:0]  frame_packet_ff, frame_packet_in;
   logic                 frame_valid_ff, frame_valid_in;
   logic                 in_frame_ff, in_frame_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;

   logic                  start, active, slot_done, frame_done, bit_val, data_slot;
   logic [TICK_CW-1:0]    tick_inc;
   logic [SLOT_CW-1:0]    slot_inc;
   logic [CFG_TICK_W-1:0] high_ticks;

   assign cmd_take = cmd_valid && !out_full;

   always_comb begin
      pending_packet_in = cmd.load ? cmd.packet : pending_packet_ff;
      packet_valid_in   = cmd.load || packet_valid_ff;

      // frame starts on the same tick, sampling a packet loaded on it
      start  = !in_frame_ff && cmd.run;
      active = in_frame_ff || start;

      frame_packet_in = start ? pending_packet_in : frame_packet_ff;
      frame_valid_in  = start ? packet_valid_in : frame_valid_ff;
      tick_in         = start ? '0 : tick_ff;
      slot_in         = start ? '0 : slot_ff;

      data_slot  = (slot_in[SLOT_BITS-1:DATA_SLOT_W] == '0);
      bit_val    = frame_packet_in[DATA_SLOT_W'(PACKET_W - 1) - slot_in[DATA_SLOT_W-1:0]];
      high_ticks = bit_val ? cfg.one_high_ticks : cfg.zero_high_ticks;

      rsp.busy_res    = active;
      rsp.frame_start = active && (tick_in == '0) && (slot_in == '0);
      rsp.line        = active && frame_valid_in && data_slot &&
                        (TICK_CW'(tick_in) < TICK_CW'(high_ticks));

      // a period of 0 or 1 ends every slot after one tick
      tick_inc   = TICK_CW'(tick_in) + TICK_CW'(1);
      slot_inc   = SLOT_CW'(slot_in) + SLOT_CW'(1);
      slot_done  = (tick_inc >= TICK_CW'(cfg.bit_period)) || (tick_in == '1);
      frame_done = (slot_inc >= SLOT_CW'(cfg.frame_slots)) || (slot_in == '1);

      in_frame_in = active;
      if (active) begin
         if (slot_done) begin
            tick_in = '0;
            if (frame_done) begin
               slot_in     = '0;
               in_frame_in = 1'b0;
            end else begin
               slot_in = slot_in + SLOT_BITS'(1);
            end
         end else begin
            tick_in = tick_in + TICK_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_valid_ff <= 1'b0;
         frame_valid_ff  <= 1'b0;
         in_frame_ff     <= 1'b0;
         tick_ff         <= '0;
         slot_ff         <= '0;
      end else if (cmd_take) begin
         packet_valid_ff <= packet_valid_in;
         frame_valid_ff  <= frame_valid_in;
         in_frame_ff     <= in_frame_in;
         tick_ff         <= tick_in;
         slot_ff         <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         pending_packet_ff <= pending_packet_in;
         frame_packet_ff   <= frame_packet_in;
      end
   end

endmodule

// ===== sv/dshot_frame_transmitter_core.sv =====
// DShot frame transmitter top level: config registers, front end, timing engine,
// result queue. Depends on dft_pkg, dft_front, dft_back and dft_fifo.
// A tick beat accepted into the command queue is taken by the timing engine and its result is
// registered into the result queue, from which it can then be popped.
// Throughput: one tick per cycle while the result queue is not full, set by the timing engine update.
// Reset (synchronous, active high) empties both queues, stops framing, clears the
// pending packet valid flag and restores the register reset values.
module dshot_frame_transmitter_core
   import dft_pkg::*;
#(
   parameter int TICK_BITS   = TICK_BITS_DEFAULT,
   parameter int SLOT_BITS   = SLOT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff;
   logic    cmd_valid, cmd_take, out_full;
   cmd_type cmd;
   rsp_type rsp_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period      <= BIT_PERIOD_RESET;
         cfg_ff.one_high_ticks  <= ONE_HIGH_TICKS_RESET;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_TICKS_RESET;
         cfg_ff.frame_slots     <= FRAME_SLOTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_PERIOD:      cfg_ff.bit_period      <= csr_write_data;
            CSR_ONE_HIGH_TICKS:  cfg_ff.one_high_ticks  <= csr_write_data;
            CSR_ZERO_HIGH_TICKS: cfg_ff.zero_high_ticks <= csr_write_data;
            CSR_FRAME_SLOTS:     cfg_ff.frame_slots     <= csr_write_data[CFG_SLOT_W-1:0];
         endcase
      end
   end

   dft_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_take  (cmd_take),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   dft_back #(
      .TICK_BITS (TICK_BITS),
      .SLOT_BITS (SLOT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .out_full  (out_full),
      .cmd_take  (cmd_take),
      .rsp       (rsp_new)
   );

   dft_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_take),
      .wr_data (rsp_new),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

   // a tick taken by the engine always leaves a result beat behind
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> !rsp_empty)
      else $error("engine took a tick but no result is waiting");

   a_line_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.line) |-> rsp_data.busy_res)
      else $error("line high outside a frame");

   a_start_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_start) |-> rsp_data.busy_res)
      else $error("frame start outside a frame");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for dshot_frame_transmitter_core: drives one tick beat at a time and
// predicts the pin level, frame start and busy flag of every tick beat. Needs dft_pkg.
module tb;
   import dft_pkg::*;

   typedef enum bit {ROW_TICK, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  bp;
      logic [15:0]  one_hi;
      logic [15:0]  zero_hi;
      logic [15:0]  slots;
      req_type      tick;
      bit           typed;
      rsp_type      want;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   req_type                req_data;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop;
   rsp_type                rsp_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // predictor copy of the timing registers and framing state
   logic [15:0] cfg_period, cfg_one, cfg_zero;
   logic [11:0] cfg_slots;
   logic [15:0] pend_pkt, frm_pkt;
   logic        pend_ok, frm_ok, running, in_frame;
   logic [15:0] tick_cnt;
   logic [11:0] slot_cnt;

   rsp_type levels_due[$];
   int      bad_beats = 0;
   bit      calm = 1'b0;

   dshot_frame_transmitter_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL dshot_frame_transmitter_core");
      $finish;
   end

   // one tick of the framer: load, run, frame start, outputs, then counter advance
   function automatic rsp_type next_pin_levels(input req_type t);
      rsp_type     o;
      logic [11:0] word;
      logic [3:0]  bitpos;
      logic [15:0] high;
      int          period, slots;
      o = '0;
      if (t.load) begin
         word     = {t.throttle, t.telemetry_request};
         pend_pkt = {word, word[11:8] ^ word[7:4] ^ word[3:0]};
         pend_ok  = 1'b1;
      end
      running = t.run;
      if (!in_frame && running) begin
         in_frame = 1'b1;
         frm_pkt  = pend_pkt;
         frm_ok   = pend_ok;
         tick_cnt = '0;
         slot_cnt = '0;
      end
      if (in_frame) begin
         period = (cfg_period == 0) ? 1 : int'(cfg_period);
         slots  = (cfg_slots == 0) ? 1 : int'(cfg_slots);
         o.busy_res    = 1'b1;
         o.frame_start = (tick_cnt == 0 && slot_cnt == 0);
         if (frm_ok && slot_cnt < DATA_SLOTS) begin
            bitpos = 4'd15 - slot_cnt[3:0];
            high   = frm_pkt[bitpos] ? cfg_one : cfg_zero;
            o.line = (tick_cnt < high);
         end
         // a counter left past a shrunk end value wraps on this advance
         if (int'(tick_cnt) + 1 >= period || tick_cnt == '1) begin
            tick_cnt = '0;
            if (int'(slot_cnt) + 1 >= slots || slot_cnt == '1) begin
               slot_cnt = '0;
               in_frame = 1'b0;
            end else begin
               slot_cnt = slot_cnt + 1'b1;
            end
         end else begin
            tick_cnt = tick_cnt + 1'b1;
         end
      end
      return o;
   endfunction

   function automatic plan_row_type tick_row(input bit run, input bit load,
                                             input logic [10:0] thr, input bit tel,
                                             input bit typed, input logic [2:0] want);
      plan_row_type r;
      r                        = '0;
      r.kind                   = ROW_TICK;
      r.tick.run               = run;
      r.tick.load              = load;
      r.tick.throttle          = thr;
      r.tick.telemetry_request = tel;
      r.typed                  = typed;
      r.want                   = rsp_type'(want);
      return r;
   endfunction

   function automatic plan_row_type cfg_row(input logic [15:0] bp, input logic [15:0] one_hi,
                                            input logic [15:0] zero_hi,
                                            input logic [15:0] slots);
      plan_row_type r;
      r         = '0;
      r.kind    = ROW_CFG;
      r.bp      = bp;
      r.one_hi  = one_hi;
      r.zero_hi = zero_hi;
      r.slots   = slots;
      return r;
   endfunction

   task automatic note_bad(input string what, input rsp_type want, input rsp_type got);
      bad_beats++;
      if (bad_beats <= 10)
         $display("%0t: %s: expected line=%b start=%b busy=%b, got line=%b start=%b busy=%b",
                  $realtime, what, want.line, want.frame_start, want.busy_res,
                  got.line, got.frame_start, got.busy_res);
   endtask

   task automatic send_tick(input req_type t, input bit typed, input rsp_type want);
      rsp_type p;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_full);
      p = next_pin_levels(t);
      levels_due.push_back(typed ? want : p);
   endtask

   // stop offering and let every outstanding beat come back, plus pipeline slack
   task automatic settle();
      req_push <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_timing(input logic [15:0] bp, input logic [15:0] one_hi,
                              input logic [15:0] zero_hi, input logic [15:0] slots);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BIT_PERIOD;
      csr_write_data   <= bp;
      @(posedge clock);
      csr_index        <= CSR_ONE_HIGH_TICKS;
      csr_write_data   <= one_hi;
      @(posedge clock);
      csr_index        <= CSR_ZERO_HIGH_TICKS;
      csr_write_data   <= zero_hi;
      @(posedge clock);
      csr_index        <= CSR_FRAME_SLOTS;
      csr_write_data   <= slots;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_period = bp;
      cfg_one    = one_hi;
      cfg_zero   = zero_hi;
      cfg_slots  = slots[11:0];
   endtask

   // result side: random stalls, one long hold-off to back the block up
   initial begin : result_side
      rsp_type got, want;
      int      popped, n;
      bit      held;
      popped = 0;
      held   = 1'b0;
      rsp_pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && popped >= 300) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            for (n = 0; n < 60; n++) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty) begin
            got = rsp_data;
            popped++;
            if (levels_due.size() == 0) begin
               note_bad("beat with nothing expected", '0, got);
            end else begin
               want = levels_due.pop_front();
               if (got.line !== want.line || got.frame_start !== want.frame_start ||
                   got.busy_res !== want.busy_res)
                  note_bad("mismatch", want, got);
            end
         end
      end
   end

   initial begin : tick_side
      plan_row_type plan[$];
      req_type      t;
      int           run_left, n_items, ph, i;
      bit           run_lvl;
      logic [15:0]  bp, one_v, zero_v, sl;

      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_BIT_PERIOD;
      csr_write_data   <= '0;
      cfg_period = BIT_PERIOD_RESET;
      cfg_one    = ONE_HIGH_TICKS_RESET;
      cfg_zero   = ZERO_HIGH_TICKS_RESET;
      cfg_slots  = FRAME_SLOTS_RESET;
      pend_pkt   = '0;
      frm_pkt    = '0;
      pend_ok    = 1'b0;
      frm_ok     = 1'b0;
      running    = 1'b0;
      in_frame   = 1'b0;
      tick_cnt   = '0;
      slot_cnt   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing first: idle, load while idle, frame of all ones
      plan.push_back(tick_row(0, 0, 11'h000, 0, 1, 3'b000));
      plan.push_back(tick_row(0, 1, 11'h7FF, 1, 1, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 1, 3'b111));
      plan.push_back(tick_row(1, 1, 11'h000, 0, 1, 3'b101));
      plan.push_back(tick_row(0, 0, 11'h000, 0, 1, 3'b101));
      // one-tick slots and one-slot frames cut the running frame short
      plan.push_back(cfg_row(16'd1, 16'd1, 16'd0, 16'd0));
      plan.push_back(tick_row(0, 0, 11'h000, 0, 1, 3'b001));
      plan.push_back(tick_row(0, 0, 11'h000, 0, 1, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 1, 3'b011));
      plan.push_back(tick_row(1, 1, 11'h555, 0, 1, 3'b111));
      // zero period, five-slot frame
      plan.push_back(cfg_row(16'd0, 16'd2, 16'd1, 16'd5));
      plan.push_back(tick_row(1, 1, 11'h2AA, 1, 1, 3'b111));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 1, 3'b101));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 0, 3'b000));
      plan.push_back(tick_row(0, 1, 11'h7FF, 0, 0, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h000, 1, 0, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 0, 3'b000));
      plan.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0FFF));
      plan.push_back(tick_row(1, 1, 11'h7FF, 1, 1, 3'b101));
      plan.push_back(tick_row(0, 1, 11'h000, 1, 0, 3'b000));
      // frame in progress while the period shrinks under it
      plan.push_back(cfg_row(16'd4, 16'd3, 16'd1, 16'hF011));
      plan.push_back(tick_row(1, 1, 11'h030, 1, 0, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h000, 0, 0, 3'b000));
      plan.push_back(tick_row(0, 1, 11'h400, 0, 0, 3'b000));
      plan.push_back(tick_row(1, 0, 11'h001, 1, 0, 3'b000));

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CFG)
            load_timing(plan[k].bp, plan[k].one_hi, plan[k].zero_hi, plan[k].slots);
         else
            send_tick(plan[k].tick, plan[k].typed, plan[k].want);
      end

      run_left = 0;
      run_lvl  = 1'b0;
      for (ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 7))
            0: bp = 16'($urandom_range(0, 1));
            1: bp = 16'hFFFF;
            2: bp = 16'($urandom_range(2, 40));
            default: bp = 16'($urandom_range(2, 9));
         endcase
         case ($urandom_range(0, 5))
            0: begin
               one_v  = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
               zero_v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            end
            1: begin
               one_v  = 16'($urandom_range(0, 65535));
               zero_v = 16'($urandom_range(0, 65535));
            end
            default: begin
               one_v  = 16'($urandom_range(0, int'(bp) + 1));
               zero_v = 16'($urandom_range(0, int'(bp) + 1));
            end
         endcase
         case ($urandom_range(0, 7))
            0, 1: sl = 16'($urandom_range(0, 15));
            2:    sl = 16'h0FFF;
            default: sl = 16'($urandom_range(17, 22));
         endcase
         sl[15:12] = 4'($urandom_range(0, 15));
         load_timing(bp, one_v, zero_v, sl);
         calm = (ph >= 10);
         n_items = $urandom_range(120, 180);
         for (i = 0; i < n_items; i++) begin
            // long run stretches with short stops, so frames run back to back
            if (run_left == 0) begin
               run_lvl  = ($urandom_range(0, 3) != 0);
               run_left = $urandom_range(1, run_lvl ? 80 : 12);
            end
            run_left--;
            t.run  = run_lvl;
            t.load = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 7))
               0: t.throttle = '0;
               1: t.throttle = '1;
               default: t.throttle = 11'($urandom_range(0, 2047));
            endcase
            t.telemetry_request = 1'($urandom_range(0, 1));
            send_tick(t, 1'b0, '0);
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (bad_beats == 0 && levels_due.size() == 0)
         $display("PASS dshot_frame_transmitter_core");
      else
         $display("FAIL dshot_frame_transmitter_core");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dft_pkg.sv
sv/dft_fifo.sv
sv/dft_front.sv
sv/dft_back.sv
sv/dshot_frame_transmitter_core.sv
tb/tb.sv
